// ===== src/ycu_pkg.sv =====
// Shared types, codes and saturating fixed-point helpers for the Yee cell
// update pipeline. No dependencies.
`default_nettype none

package ycu_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int INV_W  = 31;
    localparam int PROD_W = 2 * DATA_W;
    localparam int Q_W    = PROD_W - FRAC_W;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [INV_W-1:0]         inv_t;
    typedef logic [1:0]               axis_t;
    typedef logic [1:0]               reg_idx_t;

    typedef struct packed {
        data_t value;
        logic  sat;
    } sat_res_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic MODE_MAIN = 1'b0;
    localparam logic MODE_CPML = 1'b1;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam reg_idx_t REG_INV_X = 2'd0;
    localparam reg_idx_t REG_INV_Y = 2'd1;
    localparam reg_idx_t REG_INV_Z = 2'd2;

    localparam inv_t INV_RESET = INV_W'(65536);

    // Saturating add or subtract of two data words.
    function automatic sat_res_t sat_addsub(input data_t a, input data_t b, input logic sub);
        logic [DATA_W:0] s;
        sat_res_t        res;
        if (sub)
        begin
            s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        end
        else
        begin
            s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        end
        if (s[DATA_W] != s[DATA_W-1])
        begin
            res.value = s[DATA_W] ? DATA_MIN : DATA_MAX;
            res.sat   = 1'b1;
        end
        else
        begin
            res.value = data_t'(s[DATA_W-1:0]);
            res.sat   = 1'b0;
        end
        return res;
    endfunction

    // Floor the full product to the fixed-point grid and saturate.
    function automatic sat_res_t prod_round(input prod_t p);
        logic [Q_W-1:0] q;
        sat_res_t       res;
        q = p[PROD_W-1:FRAC_W];
        if ((&q[Q_W-1:DATA_W-1]) || !(|q[Q_W-1:DATA_W-1]))
        begin
            res.value = data_t'(q[DATA_W-1:0]);
            res.sat   = 1'b0;
        end
        else
        begin
            res.value = q[Q_W-1] ? DATA_MIN : DATA_MAX;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/ycu_mul.sv =====
// Registered signed multiplier producing the full double-width product.
// Depends on ycu_pkg.
`default_nettype none

module ycu_mul
    import ycu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire data_t a,
    input  wire data_t b,
    output prod_t      p
);

    prod_t p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== src/yee_cell_update_with_cpml_top.sv =====
// Yee cell update with CPML correction: seven-stage fixed-point pipeline.
// Depends on ycu_pkg and ycu_mul.
// Throughput: one cell per cycle unless m_tready stalls the output; three
// chained multiplies, each followed by a round-and-saturate stage, set the depth.
// Reset clears all stage valid bits and sets every reciprocal spacing to 1.0.
`default_nettype none

module yee_cell_update_with_cpml_top
    import ycu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // field_old, coef_self, curl_coef, a_hi, a_lo, b_hi, b_lo, scale_a, scale_b, aux_old
    input  wire logic [319:0] s_tdata,
    // mode, axis[1:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // field_new, aux_new
    output logic [63:0]       m_tdata,
    // saturated
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_we,
    input  wire reg_idx_t     cfg_addr,
    input  wire inv_t         cfg_data
);

    inv_t inv_x_reg, inv_y_reg, inv_z_reg;
    logic [7:1] valid_reg;
    logic [7:1] adv;

    // input unpack
    logic  in_mode;
    axis_t in_axis;
    data_t in_field_old, in_coef_self, in_curl_coef, in_a_hi, in_a_lo;
    data_t in_b_hi, in_b_lo, in_scale_a, in_scale_b, in_aux_old;

    assign in_mode      = s_tuser[0];
    assign in_axis      = s_tuser[2:1];
    assign in_field_old = data_t'(s_tdata[31:0]);
    assign in_coef_self = data_t'(s_tdata[63:32]);
    assign in_curl_coef = data_t'(s_tdata[95:64]);
    assign in_a_hi      = data_t'(s_tdata[127:96]);
    assign in_a_lo      = data_t'(s_tdata[159:128]);
    assign in_b_hi      = data_t'(s_tdata[191:160]);
    assign in_b_lo      = data_t'(s_tdata[223:192]);
    assign in_scale_a   = data_t'(s_tdata[255:224]);
    assign in_scale_b   = data_t'(s_tdata[287:256]);
    assign in_aux_old   = data_t'(s_tdata[319:288]);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg <= INV_RESET;
            inv_y_reg <= INV_RESET;
            inv_z_reg <= INV_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_INV_X: inv_x_reg <= cfg_data;
                REG_INV_Y: inv_y_reg <= cfg_data;
                REG_INV_Z: inv_z_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // stage advance and valid bits
    always_comb
    begin
        adv[7] = !valid_reg[7] || m_tready;
        for (int i = 6; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= s_tvalid;
            end
            for (int i = 2; i <= 7; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = valid_reg[7];

    // stage 1: differences
    sat_res_t da_next, db_next;
    logic     s1_mode_reg;
    axis_t    s1_axis_reg;
    data_t    s1_field_old_reg, s1_coef_self_reg, s1_curl_coef_reg;
    data_t    s1_scale_a_reg, s1_scale_b_reg, s1_aux_old_reg;
    data_t    s1_da_reg, s1_db_reg;
    logic     s1_flag_reg;

    always_comb
    begin
        da_next = sat_addsub(in_a_hi, in_a_lo, 1'b1);
        db_next = sat_addsub(in_b_hi, in_b_lo, 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_mode_reg      <= in_mode;
            s1_axis_reg      <= in_axis;
            s1_field_old_reg <= in_field_old;
            s1_coef_self_reg <= in_coef_self;
            s1_curl_coef_reg <= in_curl_coef;
            s1_scale_a_reg   <= in_scale_a;
            s1_scale_b_reg   <= in_scale_b;
            s1_aux_old_reg   <= in_aux_old;
            s1_da_reg        <= da_next.value;
            s1_db_reg        <= db_next.value;
            s1_flag_reg      <= da_next.sat || (in_mode == MODE_MAIN && db_next.sat);
        end
    end

    // stage 2: first products
    prod_t ta_prod, tb_prod, pk_prod;
    data_t pk_src;
    logic  s2_mode_reg;
    axis_t s2_axis_reg;
    data_t s2_field_old_reg, s2_curl_coef_reg, s2_aux_old_reg;
    logic  s2_flag_reg;

    assign pk_src = (s1_mode_reg == MODE_CPML) ? s1_aux_old_reg : s1_field_old_reg;

    ycu_mul u_mul_ta (.clk(clk), .en(adv[2]), .a(s1_da_reg), .b(s1_scale_a_reg), .p(ta_prod));
    ycu_mul u_mul_tb (.clk(clk), .en(adv[2]), .a(s1_db_reg), .b(s1_scale_b_reg), .p(tb_prod));
    ycu_mul u_mul_pk (.clk(clk), .en(adv[2]), .a(s1_coef_self_reg), .b(pk_src), .p(pk_prod));

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_mode_reg      <= s1_mode_reg;
            s2_axis_reg      <= s1_axis_reg;
            s2_field_old_reg <= s1_field_old_reg;
            s2_curl_coef_reg <= s1_curl_coef_reg;
            s2_aux_old_reg   <= s1_aux_old_reg;
            s2_flag_reg      <= s1_flag_reg;
        end
    end

    // stage 3: round, form curl or pass derivative
    sat_res_t ta_r, tb_r, pk_r, curl_r;
    data_t    x_next;
    logic     flag3_next;
    logic     s3_mode_reg;
    axis_t    s3_axis_reg;
    data_t    s3_field_old_reg, s3_curl_coef_reg, s3_aux_old_reg;
    data_t    s3_x_reg, s3_pk_reg;
    logic     s3_flag_reg;

    always_comb
    begin
        ta_r   = prod_round(ta_prod);
        tb_r   = prod_round(tb_prod);
        pk_r   = prod_round(pk_prod);
        curl_r = sat_addsub(ta_r.value, tb_r.value, 1'b1);
        if (s2_mode_reg == MODE_MAIN)
        begin
            x_next     = curl_r.value;
            flag3_next = s2_flag_reg || ta_r.sat || tb_r.sat || curl_r.sat || pk_r.sat;
        end
        else
        begin
            x_next     = ta_r.value;
            flag3_next = s2_flag_reg || ta_r.sat || pk_r.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_mode_reg      <= s2_mode_reg;
            s3_axis_reg      <= s2_axis_reg;
            s3_field_old_reg <= s2_field_old_reg;
            s3_curl_coef_reg <= s2_curl_coef_reg;
            s3_aux_old_reg   <= s2_aux_old_reg;
            s3_x_reg         <= x_next;
            s3_pk_reg        <= pk_r.value;
            s3_flag_reg      <= flag3_next;
        end
    end

    // stage 4: curl term or derivative times reciprocal spacing
    inv_t  inv_sel;
    data_t m4_b;
    prod_t m4_prod;
    logic  s4_mode_reg;
    data_t s4_field_old_reg, s4_curl_coef_reg, s4_aux_old_reg, s4_pk_reg;
    logic  s4_flag_reg;

    always_comb
    begin
        case (s3_axis_reg)
            AXIS_X:  inv_sel = inv_x_reg;
            AXIS_Y:  inv_sel = inv_y_reg;
            AXIS_Z:  inv_sel = inv_z_reg;
            default: inv_sel = '0;
        endcase
        if (s3_mode_reg == MODE_MAIN)
        begin
            m4_b = s3_curl_coef_reg;
        end
        else
        begin
            m4_b = data_t'({1'b0, inv_sel});
        end
    end

    ycu_mul u_mul_4 (.clk(clk), .en(adv[4]), .a(s3_x_reg), .b(m4_b), .p(m4_prod));

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_mode_reg      <= s3_mode_reg;
            s4_field_old_reg <= s3_field_old_reg;
            s4_curl_coef_reg <= s3_curl_coef_reg;
            s4_aux_old_reg   <= s3_aux_old_reg;
            s4_pk_reg        <= s3_pk_reg;
            s4_flag_reg      <= s3_flag_reg;
        end
    end

    // stage 5: main result, or new auxiliary value
    sat_res_t m4_r, sum5_r;
    logic     s5_mode_reg;
    data_t    s5_field_old_reg, s5_curl_coef_reg, s5_aux_reg, s5_field_reg;
    logic     s5_flag_reg;

    always_comb
    begin
        m4_r   = prod_round(m4_prod);
        sum5_r = sat_addsub(s4_pk_reg, m4_r.value, 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_mode_reg      <= s4_mode_reg;
            s5_field_old_reg <= s4_field_old_reg;
            s5_curl_coef_reg <= s4_curl_coef_reg;
            s5_aux_reg       <= (s4_mode_reg == MODE_MAIN) ? s4_aux_old_reg : sum5_r.value;
            s5_field_reg     <= sum5_r.value;
            s5_flag_reg      <= s4_flag_reg || m4_r.sat || sum5_r.sat;
        end
    end

    // stage 6: curl coefficient times auxiliary value
    prod_t m6_prod;
    logic  s6_mode_reg;
    data_t s6_field_old_reg, s6_aux_reg, s6_field_reg;
    logic  s6_flag_reg;

    ycu_mul u_mul_6 (.clk(clk), .en(adv[6]), .a(s5_curl_coef_reg), .b(s5_aux_reg),
        .p(m6_prod));

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_mode_reg      <= s5_mode_reg;
            s6_field_old_reg <= s5_field_old_reg;
            s6_aux_reg       <= s5_aux_reg;
            s6_field_reg     <= s5_field_reg;
            s6_flag_reg      <= s5_flag_reg;
        end
    end

    // stage 7: corrected field, output register
    sat_res_t m6_r, sum7_r;
    data_t    field_next;
    logic     flag7_next;
    data_t    out_field_reg, out_aux_reg;
    logic     out_sat_reg;

    always_comb
    begin
        m6_r   = prod_round(m6_prod);
        sum7_r = sat_addsub(s6_field_old_reg, m6_r.value, 1'b0);
        if (s6_mode_reg == MODE_CPML)
        begin
            field_next = sum7_r.value;
            flag7_next = s6_flag_reg || m6_r.sat || sum7_r.sat;
        end
        else
        begin
            field_next = s6_field_reg;
            flag7_next = s6_flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            out_field_reg <= field_next;
            out_aux_reg   <= s6_aux_reg;
            out_sat_reg   <= flag7_next;
        end
    end

    assign m_tdata = {out_aux_reg, out_field_reg};
    assign m_tuser = out_sat_reg;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[1] |-> s_tready)
        else $error("input stalled with empty first stage");

    a_stage6_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[6] && !adv[6]) |=> (valid_reg[6] && $stable(s6_field_old_reg)
            && $stable(s6_aux_reg)))
        else $error("stalled stage lost its item");

endmodule

`default_nettype wire
